[rtl/core/assert_macros.svh]
// Assertion macros used by the core controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define QLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define QLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/qle_pkg.sv]
// Shared types and constants of the Q-learning core.
package qle_pkg;

    typedef enum logic [1:0] {
        OP_LEARN      = 2'd0,
        OP_EPS_SELECT = 2'd1,
        OP_GREEDY     = 2'd2,
        OP_DECAY      = 2'd3
    } t_op;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int EPS_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_DECAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_FLOOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS       = 3'd6;

    localparam logic [16:0] LEARN_RATE_RST    = 17'd6554;
    localparam logic [16:0] DISCOUNT_RST      = 17'd64881;
    localparam logic [16:0] EXPLORE_START_RST = 17'd65536;
    localparam logic [16:0] EXPLORE_DECAY_RST = 17'd65208;
    localparam logic [16:0] EXPLORE_FLOOR_RST = 17'd655;
    localparam logic [8:0]  STATES_RST        = 9'd256;
    localparam logic [4:0]  ACTIONS_RST       = 5'd16;
    localparam logic [EPS_W-1:0] EPS_MAX      = 17'h1FFFF;

    typedef struct packed {
        logic clr;
        logic load;
        logic set_bad;
        logic scan_init;
        logic scan_next_state;
        logic scan_step;
        logic mod_init;
        logic mod_step;
        logic rd_rand;
        logic take_rand_q;
        logic take_best;
        logic rd_cur;
        logic take_cur;
        logic mul_start;
        logic mul_sel;
        logic tgt;
        logic err;
        logic nq;
        logic wr;
        logic dec1;
        logic dec2;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic bad;
        logic explore;
        logic term;
        logic clr_last;
        logic scan_done;
        logic mod_done;
        logic mul_busy;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/qle_mul.sv]
// Digit-serial signed value by unsigned Q1.16 gain, rounded and saturated.
module qle_mul #(
    parameter int Q_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [Q_WIDTH-1:0] i_x,
    input  logic        [16:0]        i_g,
    output logic                      o_busy,
    output logic signed [Q_WIDTH-1:0] o_y
);
    localparam int ND = (Q_WIDTH + 15) / 16;
    localparam int MW = ND * 16;
    localparam int AW = MW + 17;
    localparam int CW = $clog2(ND + 1);
    localparam int RW = AW - 15;
    localparam logic signed [Q_WIDTH-1:0] QMAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam logic signed [Q_WIDTH-1:0] QMIN = {1'b1, {(Q_WIDTH-1){1'b0}}};
    localparam logic [RW-1:0] QMAXU = RW'({(Q_WIDTH-1){1'b1}});

    logic [Q_WIDTH-1:0] mag_in;
    logic [MW-1:0]      r_mag;
    logic [16:0]        r_g;
    logic [AW-1:0]      r_acc;
    logic [CW-1:0]      r_cnt;
    logic               r_neg, r_run;
    logic signed [Q_WIDTH-1:0] r_y;
    logic [32:0]        pp;
    logic [AW:0]        rnd_full;
    logic [RW-1:0]      rnd;
    logic [Q_WIDTH-1:0] rnd_lo;

    assign mag_in   = i_x[Q_WIDTH-1] ? (Q_WIDTH'(~i_x) + Q_WIDTH'(1)) : Q_WIDTH'(i_x);
    assign pp       = r_mag[MW-1 -: 16] * r_g;
    assign rnd_full = {1'b0, r_acc} + (AW+1)'(32768);
    assign rnd      = rnd_full[AW:16];
    assign rnd_lo   = rnd[Q_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CW'(ND);
        end else if (r_run) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= MW'(mag_in);
            r_neg <= i_x[Q_WIDTH-1];
            r_g   <= i_g;
            r_acc <= '0;
        end else if (r_run) begin
            if (r_cnt != '0) begin
                // most significant digit first
                r_acc <= (r_acc << 16) + AW'(pp);
                r_mag <= r_mag << 16;
            end else if (rnd > QMAXU) begin
                r_y <= r_neg ? QMIN : QMAX;
            end else begin
                r_y <= r_neg ? Q_WIDTH'(~rnd_lo + Q_WIDTH'(1)) : rnd_lo;
            end
        end
    end

    assign o_busy = r_run;
    assign o_y    = r_y;
endmodule

[rtl/core/qle_dp.sv]
// Datapath: configuration, Q table, scan, modulo, arithmetic and result register.
module qle_dp #(
    parameter int MAX_STATES  = 256,
    parameter int MAX_ACTIONS = 16,
    parameter int Q_WIDTH     = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qle_pkg::t_cmd                    i_cmd,
    output qle_pkg::t_sts                    o_sts,
    input  logic                             i_cfg_we,
    input  logic [qle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                       i_opcode,
    input  logic [7:0]                       i_current_state,
    input  logic [3:0]                       i_action_index,
    input  logic signed [31:0]               i_reward,
    input  logic [7:0]                       i_next_state_index,
    input  logic                             i_terminal,
    input  logic [15:0]                      i_explore_draw,
    input  logic [15:0]                      i_action_draw,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [3:0]                       o_chosen_action,
    output logic signed [31:0]               o_q_result,
    output logic                             o_explored,
    output logic [qle_pkg::EPS_W-1:0]        o_epsilon_now,
    output logic                             o_status
);
    localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
    localparam int TW    = $clog2(DEPTH);
    localparam int XW    = (Q_WIDTH > 32) ? Q_WIDTH : 32;
    localparam logic signed [Q_WIDTH-1:0] QMAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam logic signed [Q_WIDTH-1:0] QMIN = {1'b1, {(Q_WIDTH-1){1'b0}}};
    localparam logic signed [XW:0] QMAX_X = (XW+1)'(QMAX);
    localparam logic signed [XW:0] QMIN_X = (XW+1)'(QMIN);

    function automatic logic signed [Q_WIDTH-1:0] sat_sum(
        input logic signed [Q_WIDTH-1:0] a,
        input logic signed [Q_WIDTH-1:0] b,
        input logic                      sub
    );
        logic [Q_WIDTH:0] s;
        s = sub ? ({a[Q_WIDTH-1], a} - {b[Q_WIDTH-1], b})
                : ({a[Q_WIDTH-1], a} + {b[Q_WIDTH-1], b});
        if (s[Q_WIDTH] != s[Q_WIDTH-1]) begin
            return s[Q_WIDTH] ? QMIN : QMAX;
        end
        return s[Q_WIDTH-1:0];
    endfunction

    function automatic logic [TW-1:0] slot(input logic [7:0] s, input logic [4:0] a);
        logic [31:0] f;
        f = 32'(s) * 32'(MAX_ACTIONS) + 32'(a);
        return f[TW-1:0];
    endfunction

    // configuration
    logic [16:0] r_alpha, r_gamma, r_decay, r_floor;
    logic [8:0]  r_states;
    logic [4:0]  r_actions;
    logic [qle_pkg::EPS_W-1:0] r_eps;

    // latched item
    qle_pkg::t_op r_op;
    logic [7:0]  r_s, r_ns;
    logic [3:0]  r_a;
    logic        r_term;
    logic [15:0] r_edraw, r_adraw;
    logic signed [Q_WIDTH-1:0] r_rew;

    logic signed [XW:0]        rew_x;
    logic signed [Q_WIDTH-1:0] rew_clamp;

    // table
    logic signed [Q_WIDTH-1:0] mem [DEPTH];
    logic signed [Q_WIDTH-1:0] r_rdata, wdata;
    logic [TW-1:0] raddr, waddr, r_clr_cnt, r_cur_addr;
    logic          we;

    // scan
    logic [7:0] r_scan_base;
    logic [4:0] r_scan_idx, r_cmp_idx, r_best_idx;
    logic       r_cmp_v, issuing;
    logic signed [Q_WIDTH-1:0] r_best_val;

    // modulo
    logic [4:0]  r_rem, r_mcnt;
    logic [15:0] r_div;
    logic [5:0]  mod_t, mod_n;

    // arithmetic
    logic signed [Q_WIDTH-1:0] r_cur, r_tgt, r_err, r_nq, mx, mul_x, mul_y;
    logic [16:0] mul_g;
    logic        mul_busy;
    logic [33:0] r_eprod;
    logic [34:0] e_full;
    logic [18:0] e_rnd;
    logic [16:0] e_cap;

    // result
    logic [4:0] r_res_act;
    logic signed [Q_WIDTH-1:0] r_res_q;
    logic       r_res_expl, r_res_bad, r_ovld;
    logic signed [XW-1:0] res_qx;

    // range checks
    logic [4:0] a_eff;
    logic       s_bad, ns_bad, a_bad, a_zero, bad;

    assign a_eff  = (32'(r_actions) > 32'(MAX_ACTIONS)) ? 5'(MAX_ACTIONS) : r_actions;
    assign s_bad  = (32'(r_s) >= 32'(MAX_STATES)) || ({1'b0, r_s} >= r_states);
    assign ns_bad = (32'(r_ns) >= 32'(MAX_STATES)) || ({1'b0, r_ns} >= r_states);
    assign a_bad  = {1'b0, r_a} >= a_eff;
    assign a_zero = a_eff == 5'd0;

    always_comb begin
        case (r_op)
            qle_pkg::OP_LEARN:      bad = s_bad || ns_bad || a_bad;
            qle_pkg::OP_EPS_SELECT: bad = s_bad || a_zero;
            qle_pkg::OP_GREEDY:     bad = s_bad || a_zero;
            default:                bad = 1'b0;
        endcase
    end

    assign rew_x     = (XW+1)'(i_reward);
    assign rew_clamp = (rew_x > QMAX_X) ? QMAX :
                       (rew_x < QMIN_X) ? QMIN : rew_x[Q_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= qle_pkg::LEARN_RATE_RST;
            r_gamma   <= qle_pkg::DISCOUNT_RST;
            r_decay   <= qle_pkg::EXPLORE_DECAY_RST;
            r_floor   <= qle_pkg::EXPLORE_FLOOR_RST;
            r_states  <= qle_pkg::STATES_RST;
            r_actions <= qle_pkg::ACTIONS_RST;
            r_eps     <= qle_pkg::EXPLORE_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qle_pkg::CFG_LEARN_RATE:    r_alpha <= i_cfg_data;
                qle_pkg::CFG_DISCOUNT:      r_gamma <= i_cfg_data;
                qle_pkg::CFG_EXPLORE_START: r_eps   <= i_cfg_data;
                qle_pkg::CFG_EXPLORE_DECAY: r_decay   <= i_cfg_data;
                qle_pkg::CFG_EXPLORE_FLOOR: r_floor   <= i_cfg_data;
                qle_pkg::CFG_STATES:        r_states  <= i_cfg_data[8:0];
                qle_pkg::CFG_ACTIONS:       r_actions <= i_cfg_data[4:0];
                default: ;
            endcase
        end else if (i_cmd.dec2) begin
            r_eps <= (e_cap < r_floor) ? r_floor : e_cap;
        end
    end

    // epsilon decay
    assign e_full = {1'b0, r_eprod} + 35'd32768;
    assign e_rnd  = e_full[34:16];
    assign e_cap  = (e_rnd > 19'(qle_pkg::EPS_MAX)) ? qle_pkg::EPS_MAX : e_rnd[16:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec1) begin
            r_eprod <= r_eps * r_decay;
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= qle_pkg::t_op'(i_opcode);
            r_s     <= i_current_state;
            r_a     <= i_action_index;
            r_rew   <= rew_clamp;
            r_ns    <= i_next_state_index;
            r_term  <= i_terminal;
            r_edraw <= i_explore_draw;
            r_adraw <= i_action_draw;
        end
    end

    // table port
    assign we    = i_cmd.clr || i_cmd.wr;
    assign waddr = i_cmd.clr ? r_clr_cnt : r_cur_addr;
    assign wdata = i_cmd.clr ? '0 : r_nq;

    always_comb begin
        if (i_cmd.rd_cur) begin
            raddr = slot(r_s, {1'b0, r_a});
        end else if (i_cmd.rd_rand) begin
            raddr = slot(r_s, r_rem);
        end else begin
            raddr = slot(r_scan_base, r_scan_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cur) begin
            r_cur_addr <= raddr;
        end
        if (i_cmd.take_cur) begin
            r_cur <= r_rdata;
        end
    end

    // scan for the first action of highest value
    assign issuing = r_scan_idx < a_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_cmp_v <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_v <= issuing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_idx  <= '0;
            r_scan_base <= i_cmd.scan_next_state ? r_ns : r_s;
        end else if (i_cmd.scan_step) begin
            if (issuing) begin
                r_scan_idx <= r_scan_idx + 5'd1;
            end
            r_cmp_idx <= r_scan_idx;
            if (r_cmp_v && ((r_cmp_idx == 5'd0) || (r_rdata > r_best_val))) begin
                r_best_val <= r_rdata;
                r_best_idx <= r_cmp_idx;
            end
        end
    end

    // draw modulo action count, one bit a cycle
    assign mod_t = {r_rem, r_div[15]};
    assign mod_n = (mod_t >= {1'b0, a_eff}) ? (mod_t - {1'b0, a_eff}) : mod_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_cmd.mod_init) begin
            r_mcnt <= 5'd16;
        end else if (i_cmd.mod_step) begin
            r_mcnt <= r_mcnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_init) begin
            r_rem <= '0;
            r_div <= r_adraw;
        end else if (i_cmd.mod_step) begin
            r_rem <= mod_n[4:0];
            r_div <= r_div << 1;
        end
    end

    // learn arithmetic
    assign mx    = r_term ? '0 : r_best_val;
    assign mul_x = i_cmd.mul_sel ? r_err : mx;
    assign mul_g = i_cmd.mul_sel ? r_alpha : r_gamma;

    qle_mul #(
        .Q_WIDTH (Q_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (mul_x),
        .i_g     (mul_g),
        .o_busy  (mul_busy),
        .o_y     (mul_y)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt) begin
            r_tgt <= sat_sum(r_rew, mul_y, 1'b0);
        end
        if (i_cmd.err) begin
            r_err <= sat_sum(r_tgt, r_cur, 1'b1);
        end
        if (i_cmd.nq) begin
            r_nq <= sat_sum(r_cur, mul_y, 1'b0);
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_act  <= '0;
            r_res_q    <= '0;
            r_res_expl <= 1'b0;
            r_res_bad  <= 1'b0;
        end else begin
            if (i_cmd.set_bad) begin
                r_res_bad <= 1'b1;
            end
            if (i_cmd.take_best) begin
                r_res_act <= r_best_idx;
                r_res_q   <= r_best_val;
            end
            if (i_cmd.rd_rand) begin
                r_res_act  <= r_rem;
                r_res_expl <= 1'b1;
            end
            if (i_cmd.take_rand_q) begin
                r_res_q <= r_rdata;
            end
            if (i_cmd.wr) begin
                r_res_q <= r_nq;
            end
        end
    end

    // output register
    assign res_qx = XW'(r_res_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_chosen_action <= r_res_act[3:0];
            o_q_result      <= res_qx[31:0];
            o_explored      <= r_res_expl;
            o_epsilon_now   <= r_eps;
            o_status        <= r_res_bad;
        end
    end

    assign o_out_valid = r_ovld;

    assign o_sts.op        = r_op;
    assign o_sts.bad       = bad;
    assign o_sts.explore   = {1'b0, r_edraw} < r_eps;
    assign o_sts.term      = r_term;
    assign o_sts.clr_last  = r_clr_cnt == TW'(DEPTH - 1);
    assign o_sts.scan_done = !issuing && !r_cmp_v;
    assign o_sts.mod_done  = r_mcnt == 5'd0;
    assign o_sts.mul_busy  = mul_busy;
    assign o_sts.out_free  = !r_ovld || !i_out_stall;
endmodule

[rtl/core/qle_ctrl.sv]
// Controller state machine sequencing each item through the datapath.
`include "assert_macros.svh"

module qle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  qle_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output qle_pkg::t_cmd o_cmd
);
    typedef enum logic [18:0] {
        ST_CLEAR   = 19'h00001,
        ST_IDLE    = 19'h00002,
        ST_DISP    = 19'h00004,
        ST_MOD     = 19'h00008,
        ST_RDQ     = 19'h00010,
        ST_GETQ    = 19'h00020,
        ST_SCAN    = 19'h00040,
        ST_RDCUR   = 19'h00080,
        ST_GETCUR  = 19'h00100,
        ST_MUL1    = 19'h00200,
        ST_TGT     = 19'h00400,
        ST_ERR     = 19'h00800,
        ST_MUL2GO  = 19'h01000,
        ST_MUL2    = 19'h02000,
        ST_NQ      = 19'h04000,
        ST_WR      = 19'h08000,
        ST_DECAY   = 19'h10000,
        ST_DECAY2  = 19'h20000,
        ST_DONE    = 19'h40000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.bad) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    case (i_sts.op)
                        qle_pkg::OP_LEARN: begin
                            if (i_sts.term) begin
                                n_state = ST_RDCUR;
                            end else begin
                                o_cmd.scan_init       = 1'b1;
                                o_cmd.scan_next_state = 1'b1;
                                n_state               = ST_SCAN;
                            end
                        end
                        qle_pkg::OP_EPS_SELECT: begin
                            if (i_sts.explore) begin
                                o_cmd.mod_init = 1'b1;
                                n_state        = ST_MOD;
                            end else begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = ST_SCAN;
                            end
                        end
                        qle_pkg::OP_GREEDY: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_DECAY;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = ST_RDQ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            ST_RDQ: begin
                o_cmd.rd_rand = 1'b1;
                n_state       = ST_GETQ;
            end
            ST_GETQ: begin
                o_cmd.take_rand_q = 1'b1;
                n_state           = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.op == qle_pkg::OP_LEARN) begin
                        n_state = ST_RDCUR;
                    end else begin
                        o_cmd.take_best = 1'b1;
                        n_state         = ST_DONE;
                    end
                end
            end
            ST_RDCUR: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = ST_GETCUR;
            end
            ST_GETCUR: begin
                o_cmd.take_cur  = 1'b1;
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MUL1;
            end
            ST_MUL1: begin
                if (!i_sts.mul_busy) begin
                    n_state = ST_TGT;
                end
            end
            ST_TGT: begin
                o_cmd.tgt = 1'b1;
                n_state   = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = ST_MUL2GO;
            end
            ST_MUL2GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = 1'b1;
                n_state         = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_sel = 1'b1;
                if (!i_sts.mul_busy) begin
                    n_state = ST_NQ;
                end
            end
            ST_NQ: begin
                o_cmd.nq = 1'b1;
                n_state  = ST_WR;
            end
            ST_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DECAY: begin
                o_cmd.dec1 = 1'b1;
                n_state    = ST_DECAY2;
            end
            ST_DECAY2: begin
                o_cmd.dec2 = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

    `QLE_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_state == ST_DISP)
    `QLE_ASSERT(a_load_when_free, i_clk, i_rst_n, !o_cmd.out_load || i_sts.out_free)
    `QLE_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, r_state != ST_CLEAR,
        r_state != ST_CLEAR)
    `QLE_ASSERT(a_scan_mul_idle, i_clk, i_rst_n, (r_state != ST_SCAN) || !i_sts.mul_busy)
endmodule

[rtl/core/tabular_q_learning_engine_core.sv]
// Top level of the tabular Q-learning engine core.
//
// Input channel: i_in_valid / o_in_stall with one operation per item (learn,
// epsilon-greedy select, greedy select, episode-end decay). Output channel:
// o_out_valid / i_out_stall, exactly one result item per input item, in order.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data; write
// only while no item is in flight.
// One item is worked at a time by a sequencer over a Q table with one read
// and one write port. A learn scans the next state's actions (no scan when
// terminal) and runs the digit-serial multiplier twice; a select that does
// not explore scans the current state's actions; an explored select takes
// the draw modulo the action count bit-serially; a decay scales epsilon, not
// below the floor; a rejected item goes straight to its result.
// After reset the table is cleared one entry a cycle, MAX_STATES*MAX_ACTIONS
// entries (4096 at default size), with o_in_stall high; configuration writes
// are taken during that pass.
// A finished result sits in the output register while i_out_stall is high;
// the sequencer waits for it to drain before its next result, and o_in_stall
// stays high until that result is handed over.
module tabular_q_learning_engine_core #(
    parameter int MAX_STATES  = 256,
    parameter int MAX_ACTIONS = 16,
    parameter int Q_WIDTH     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [qle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [7:0]                     i_current_state,
    input  logic [3:0]                     i_action_index,
    input  logic signed [31:0]             i_reward,
    input  logic [7:0]                     i_next_state_index,
    input  logic                           i_terminal,
    input  logic [15:0]                    i_explore_draw,
    input  logic [15:0]                    i_action_draw,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [3:0]                     o_chosen_action,
    output logic signed [31:0]             o_q_result,
    output logic                           o_explored,
    output logic [qle_pkg::EPS_W-1:0]      o_epsilon_now,
    output logic                           o_status
);
    qle_pkg::t_cmd cmd;
    qle_pkg::t_sts sts;

    qle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    qle_dp #(
        .MAX_STATES  (MAX_STATES),
        .MAX_ACTIONS (MAX_ACTIONS),
        .Q_WIDTH     (Q_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_opcode           (i_opcode),
        .i_current_state    (i_current_state),
        .i_action_index     (i_action_index),
        .i_reward           (i_reward),
        .i_next_state_index (i_next_state_index),
        .i_terminal         (i_terminal),
        .i_explore_draw     (i_explore_draw),
        .i_action_draw      (i_action_draw),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_chosen_action    (o_chosen_action),
        .o_q_result         (o_q_result),
        .o_explored         (o_explored),
        .o_epsilon_now      (o_epsilon_now),
        .o_status           (o_status)
    );
endmodule

[verif/tb.sv]
// Self-checking testbench for the tabular Q-learning engine core.
`timescale 1ns / 100ps

module tb;
    localparam int NS = 256;
    localparam int NA = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 60;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        qle_pkg::t_op op;
        bit [7:0]    cs;
        bit [3:0]    ai;
        bit [31:0]   rw;
        bit [7:0]    ns;
        bit          term;
        bit [15:0]   ed;
        bit [15:0]   ad;
    } t_item;

    typedef struct {
        bit [3:0]  act;
        bit [31:0] q;
        bit        xpl;
        bit [16:0] eps;
        bit        st;
    } t_res;

    typedef struct {
        t_item it;
        bit    chk;
        t_res  r;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [qle_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [qle_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid, o_in_stall;
    logic [1:0] i_opcode;
    logic [7:0] i_current_state, i_next_state_index;
    logic [3:0] i_action_index;
    logic signed [31:0] i_reward;
    logic i_terminal;
    logic [15:0] i_explore_draw, i_action_draw;
    logic o_out_valid, i_out_stall;
    logic [3:0] o_chosen_action;
    logic signed [31:0] o_q_result;
    logic o_explored;
    logic [qle_pkg::EPS_W-1:0] o_epsilon_now;
    logic o_status;

    tabular_q_learning_engine_core u_top (.*);

    // model copy of the engine
    longint q_tab [NS*NA];
    int unsigned alpha_r, gamma_r, eps_start_r, eps_decay_r, eps_floor_r;
    int unsigned states_r, actions_r, eps_lvl;

    t_res pending_q[$];
    int errors = 0;
    int snd_idle = 0, rcv_idle = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int cyc = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall, or one long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result act=%0d q=%h", $realtime,
                         o_chosen_action, o_q_result);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_chosen_action !== e.act || o_q_result !== e.q ||
                    o_explored !== e.xpl || o_epsilon_now !== e.eps ||
                    o_status !== e.st) begin
                    $display("%0t: mismatch exp act=%0d q=%h xpl=%0d eps=%0d st=%0d",
                             $realtime, e.act, e.q, e.xpl, e.eps, e.st);
                    $display("%0t:          got act=%0d q=%h xpl=%0d eps=%0d st=%0d",
                             $realtime, o_chosen_action, o_q_result, o_explored,
                             o_epsilon_now, o_status);
                    errors++;
                end
            end
        end
    end

    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // x * g / 65536, rounded half away from zero
    function automatic longint scale_q(longint x, int unsigned g);
        longint mag, r;
        mag = (x < 0) ? -x : x;
        r = (mag * longint'(g) + 32768) >>> 16;
        return clamp_q((x < 0) ? -r : r);
    endfunction

    function automatic int unsigned best_of(int unsigned s, int unsigned na,
                                            output longint bv);
        int unsigned best;
        best = 0;
        bv = q_tab[s*NA];
        for (int unsigned a = 1; a < na; a++)
            if (q_tab[s*NA+a] > bv) begin
                bv = q_tab[s*NA+a];
                best = a;
            end
        return best;
    endfunction

    function automatic t_res predict(t_item it);
        t_res r;
        int unsigned S, A;
        longint cur, mx, tgt, nq;
        longint unsigned e;
        S = (states_r > NS) ? NS : states_r;
        A = (actions_r > NA) ? NA : actions_r;
        r = '{default: 0};
        case (it.op)
            qle_pkg::OP_LEARN: begin
                if (it.cs >= S || it.ns >= S || it.ai >= A) begin
                    r.st = 1'b1;
                end else begin
                    cur = q_tab[it.cs*NA + it.ai];
                    mx = 0;
                    if (!it.term) void'(best_of(it.ns, A, mx));
                    tgt = clamp_q(longint'(signed'(it.rw)) + scale_q(mx, gamma_r));
                    nq = clamp_q(cur + scale_q(clamp_q(tgt - cur), alpha_r));
                    q_tab[it.cs*NA + it.ai] = nq;
                    r.q = nq[31:0];
                end
            end
            qle_pkg::OP_EPS_SELECT, qle_pkg::OP_GREEDY: begin
                if (it.cs >= S || A == 0) begin
                    r.st = 1'b1;
                end else if (it.op == qle_pkg::OP_EPS_SELECT && it.ed < eps_lvl) begin
                    r.xpl = 1'b1;
                    r.act = 4'(it.ad % A);
                    r.q = q_tab[it.cs*NA + r.act][31:0];
                end else begin
                    r.act = 4'(best_of(it.cs, A, mx));
                    r.q = mx[31:0];
                end
            end
            default: begin
                e = (longint'(eps_lvl) * eps_decay_r + 32768) >> 16;
                if (e > 131071) e = 131071;
                if (e < eps_floor_r) e = eps_floor_r;
                eps_lvl = 32'(e);
            end
        endcase
        r.eps = 17'(eps_lvl);
        return r;
    endfunction

    task automatic write_reg(logic [qle_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= qle_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            qle_pkg::CFG_LEARN_RATE:    alpha_r = val & 17'h1FFFF;
            qle_pkg::CFG_DISCOUNT:      gamma_r = val & 17'h1FFFF;
            qle_pkg::CFG_EXPLORE_START: begin
                eps_start_r = val & 17'h1FFFF;
                eps_lvl = eps_start_r;
            end
            qle_pkg::CFG_EXPLORE_DECAY: eps_decay_r = val & 17'h1FFFF;
            qle_pkg::CFG_EXPLORE_FLOOR: eps_floor_r = val & 17'h1FFFF;
            qle_pkg::CFG_STATES:        states_r = val & 9'h1FF;
            default:                    actions_r = val & 5'h1F;
        endcase
    endtask

    task automatic write_all(int unsigned v[7]);
        write_reg(qle_pkg::CFG_LEARN_RATE, v[0]);
        write_reg(qle_pkg::CFG_DISCOUNT, v[1]);
        write_reg(qle_pkg::CFG_EXPLORE_START, v[2]);
        write_reg(qle_pkg::CFG_EXPLORE_DECAY, v[3]);
        write_reg(qle_pkg::CFG_EXPLORE_FLOOR, v[4]);
        write_reg(qle_pkg::CFG_STATES, v[5]);
        write_reg(qle_pkg::CFG_ACTIONS, v[6]);
    endtask

    // offer one item and hold it until the block takes it
    task automatic send_item(t_item it, bit chk, t_res typed);
        t_res p;
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= it.op;
        i_current_state <= it.cs;
        i_action_index <= it.ai;
        i_reward <= it.rw;
        i_next_state_index <= it.ns;
        i_terminal <= it.term;
        i_explore_draw <= it.ed;
        i_action_draw <= it.ad;
        p = predict(it);
        pending_q.push_back(chk ? typed : p);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_item rand_item();
        t_item it;
        int unsigned S, A, k;
        S = (states_r > NS) ? NS : states_r;
        A = (actions_r > NA) ? NA : actions_r;
        k = $urandom_range(99);
        it.op = (k < 45) ? qle_pkg::OP_LEARN : (k < 65) ? qle_pkg::OP_EPS_SELECT :
                (k < 85) ? qle_pkg::OP_GREEDY : qle_pkg::OP_DECAY;
        // keep most items on a few in-range states so the table fills in
        if (S == 0 || $urandom_range(99) < 12) begin
            it.cs = 8'($urandom);
            it.ns = 8'($urandom);
        end else begin
            it.cs = 8'($urandom_range(((S < 8) ? S : 8) - 1));
            it.ns = 8'($urandom_range(((S < 8) ? S : 8) - 1));
        end
        it.ai = 4'((A == 0 || $urandom_range(99) < 10) ? $urandom : $urandom_range(A - 1));
        k = $urandom_range(99);
        if (k < 70) it.rw = $urandom_range(8 << 16) - (4 << 16);
        else if (k < 90) it.rw = $urandom;
        else it.rw = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        it.term = ($urandom_range(99) < 20);
        it.ed = 16'($urandom);
        it.ad = 16'($urandom);
        return it;
    endfunction

    t_row rows[$];

    function automatic t_row mk(qle_pkg::t_op op, bit [7:0] cs, bit [3:0] ai,
                                bit [31:0] rw, bit [7:0] ns, bit term, bit [15:0] ed,
                                bit [15:0] ad, bit chk, t_res r);
        t_row x;
        x.it = '{op, cs, ai, rw, ns, term, ed, ad};
        x.chk = chk;
        x.r = r;
        return x;
    endfunction

    initial begin
        int unsigned cfg[7];
        int n_items;
        t_res none;
        none = '{default: 0};

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = '0;
        i_current_state = '0;
        i_action_index = '0;
        i_reward = '0;
        i_next_state_index = '0;
        i_terminal = 1'b0;
        i_explore_draw = '0;
        i_action_draw = '0;

        foreach (q_tab[i]) q_tab[i] = 0;
        alpha_r = qle_pkg::LEARN_RATE_RST;
        gamma_r = qle_pkg::DISCOUNT_RST;
        eps_start_r = qle_pkg::EXPLORE_START_RST;
        eps_decay_r = qle_pkg::EXPLORE_DECAY_RST;
        eps_floor_r = qle_pkg::EXPLORE_FLOOR_RST;
        states_r = qle_pkg::STATES_RST;
        actions_r = qle_pkg::ACTIONS_RST;
        eps_lvl = eps_start_r;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: values readable at a glance are typed in
        rows.push_back(mk(qle_pkg::OP_GREEDY, 0, 0, 0, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 65536, 0}));
        rows.push_back(mk(qle_pkg::OP_EPS_SELECT, 255, 0, 0, 0, 0, 0, 16'hFFFF, 1,
                          '{15, 0, 1, 65536, 0}));
        rows.push_back(mk(qle_pkg::OP_LEARN, 0, 0, 32'h7FFFFFFF, 255, 1, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_LEARN, 0, 1, 32'h80000000, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_LEARN, 255, 15, 32'h00010000, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_LEARN, 0, 2, 32'h7FFFFFFF, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_GREEDY, 0, 0, 0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_GREEDY, 255, 0, 0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_EPS_SELECT, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_EPS_SELECT, 0, 0, 0, 0, 0, 0, 16'h1234, 0, none));
        foreach (rows[i]) send_item(rows[i].it, rows[i].chk, rows[i].r);
        drain();

        // out-of-range indices, then items at the edge of the new range
        cfg = '{65536, 65536, 1000, 65536, 0, 100, 10};
        write_all(cfg);
        rows.delete();
        rows.push_back(mk(qle_pkg::OP_LEARN, 100, 0, 5, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 1000, 1}));
        rows.push_back(mk(qle_pkg::OP_LEARN, 0, 0, 5, 100, 1, 0, 0, 1,
                          '{0, 0, 0, 1000, 1}));
        rows.push_back(mk(qle_pkg::OP_LEARN, 99, 10, 5, 99, 1, 0, 0, 1,
                          '{0, 0, 0, 1000, 1}));
        rows.push_back(mk(qle_pkg::OP_GREEDY, 200, 0, 0, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 1000, 1}));
        rows.push_back(mk(qle_pkg::OP_EPS_SELECT, 100, 0, 0, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 1000, 1}));
        rows.push_back(mk(qle_pkg::OP_LEARN, 99, 9, 32'hFFFF0000, 99, 0, 0, 0, 0, none));
        rows.push_back(mk(qle_pkg::OP_EPS_SELECT, 99, 0, 0, 0, 0, 999, 16'hFFFF, 0, none));
        rows.push_back(mk(qle_pkg::OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, none));
        foreach (rows[i]) send_item(rows[i].it, rows[i].chk, rows[i].r);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cfg = '{6554, 64881, 65536, 65208, 655, 256, 16};
                1: cfg = '{65536, 65536, 30000, 65536, 0, 16, 4};
                2: cfg = '{1, 0, 0, 0, 0, 1, 1};
                3: cfg = '{131071, 131071, 131071, 131071, 131071, 511, 31};
                4: cfg = '{32768, 50000, 40000, 60000, 2000, 0, 0};
                default: cfg = '{$urandom_range(1, 65536), $urandom_range(65536),
                                 $urandom_range(65536), $urandom_range(65536),
                                 $urandom_range(65536), $urandom_range(1, 256),
                                 $urandom_range(1, 16)};
            endcase
            write_all(cfg);
            snd_idle = (ph < 2) ? 6 : (ph < 4) ? 48 : 0;
            rcv_idle = (ph < 2) ? 48 : (ph < 4) ? 6 : 0;
            // long receiver hold-off so the block backs up into its input
            if (ph == 1) hold_req = 1'b1;
            n_items = (ph == 4) ? 30 : 115;
            for (int i = 0; i < n_items; i++) send_item(rand_item(), 0, none);
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
